[rtl/core/mpq_pkg.sv]
`timescale 1ns / 1ps

package mpq_pkg;

   // Port field widths, fixed by the channel format
   localparam int IN_VALUE_WIDTH   = 16;
   localparam int OUT_VALUE_WIDTH  = 16;
   localparam int STATUS_WIDTH     = 2;
   localparam int FILL_COUNT_WIDTH = 5;

   // Request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_TAKE,
      ST_DONE
   } mpq_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rem_read;
      logic ins_read;
      logic ins_shift;
      logic ins_put;
      logic rem_take;
      logic load_rsp;
   } mpq_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_remove;
      logic is_ok;
      logic k_zero;
      logic k_one;
      logic shift_needed;
   } mpq_sts_type;

endpackage

[rtl/core/mpq_req_if.sv]
`timescale 1ns / 1ps

interface mpq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic [mpq_pkg::IN_VALUE_WIDTH-1:0] in_value;

   modport source (output valid, output req_type, output in_value, input ready);
   modport sink (input valid, input req_type, input in_value, output ready);
endinterface

[rtl/core/mpq_rsp_if.sv]
`timescale 1ns / 1ps

interface mpq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mpq_pkg::OUT_VALUE_WIDTH-1:0]  out_value;
   logic                                 out_valid;
   logic [mpq_pkg::STATUS_WIDTH-1:0]     status;
   logic [mpq_pkg::FILL_COUNT_WIDTH-1:0] fill_count;

   modport source (output valid, output out_value, output out_valid, output status,
                   output fill_count, input ready);
   modport sink (input valid, input out_value, input out_valid, input status,
                 input fill_count, output ready);
endinterface

[rtl/core/mpq_ram.sv]
`timescale 1ns / 1ps

module mpq_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mpq_ctrl.sv]
`timescale 1ns / 1ps

module mpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mpq_pkg::mpq_sts_type sts,
   output mpq_pkg::mpq_cmd_type cmd
);

   mpq_pkg::mpq_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         mpq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = mpq_pkg::ST_CHECK;
            end
         end
         mpq_pkg::ST_CHECK: begin
            if (!sts.is_ok) begin
               state_in = mpq_pkg::ST_DONE;
            end else if (sts.is_remove) begin
               cmd.rem_read = 1'b1;
               state_in     = mpq_pkg::ST_REM_TAKE;
            end else if (sts.k_zero) begin
               state_in = mpq_pkg::ST_INS_PUT;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = mpq_pkg::ST_INS_CMP;
            end
         end
         mpq_pkg::ST_INS_CMP: begin
            // move larger entries up one slot until the gap reaches the new value
            if (sts.shift_needed) begin
               cmd.ins_shift = 1'b1;
               state_in      = sts.k_one ? mpq_pkg::ST_INS_PUT : mpq_pkg::ST_INS_CMP;
            end else begin
               cmd.ins_put = 1'b1;
               state_in    = mpq_pkg::ST_DONE;
            end
         end
         mpq_pkg::ST_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = mpq_pkg::ST_DONE;
         end
         mpq_pkg::ST_REM_TAKE: begin
            cmd.rem_take = 1'b1;
            state_in     = mpq_pkg::ST_DONE;
         end
         mpq_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpq_pkg::ST_DONE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == mpq_pkg::ST_DONE))
      else $error("pending response would be overwritten");

   a_cmp_is_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpq_pkg::ST_INS_CMP) |-> !sts.is_remove)
      else $error("insert walk running for a remove request");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response dropped before it was taken");

endmodule

[rtl/core/mpq_dpath.sv]
`timescale 1ns / 1ps

module mpq_dpath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpq_pkg::mpq_cmd_type                   cmd,
   output mpq_pkg::mpq_sts_type                   sts,
   input  logic                                   req_type,
   input  logic [mpq_pkg::IN_VALUE_WIDTH-1:0]     in_value,
   output logic [mpq_pkg::OUT_VALUE_WIDTH-1:0]    out_value,
   output logic                                   out_valid,
   output logic [mpq_pkg::STATUS_WIDTH-1:0]       status,
   output logic [mpq_pkg::FILL_COUNT_WIDTH-1:0]   fill_count
);

   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int OVW = mpq_pkg::OUT_VALUE_WIDTH;
   localparam int FCW = mpq_pkg::FILL_COUNT_WIDTH;

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   remove_ff;
   logic [mpq_pkg::STATUS_WIDTH-1:0] status_ff;

   logic [OVW-1:0]         rsp_value_ff;
   logic                   rsp_vld_ff;
   logic [mpq_pkg::STATUS_WIDTH-1:0] rsp_status_ff;
   logic [FCW-1:0]         rsp_fill_ff;

   logic [VALUE_WIDTH-1:0] rd_data;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]          rd_addr;
   logic [CW-1:0]          count_m1, k_m1, k_m2;
   logic                   rd_en, wr_en;
   logic [mpq_pkg::STATUS_WIDTH-1:0] status_new;

   assign count_m1 = count_ff - CW'(1);
   assign k_m1     = k_ff - CW'(1);
   assign k_m2     = k_ff - CW'(2);

   always_comb begin
      if (req_type == mpq_pkg::REQ_REMOVE) begin
         status_new = (count_ff == '0) ? mpq_pkg::STATUS_EMPTY : mpq_pkg::STATUS_OK;
      end else begin
         status_new = (count_ff == CW'(QUEUE_DEPTH)) ? mpq_pkg::STATUS_FULL
                                                      : mpq_pkg::STATUS_OK;
      end
   end

   always_comb begin
      count_in = count_ff;
      k_in     = k_ff;
      value_in = value_ff;
      if (cmd.accept) begin
         k_in     = count_ff;
         value_in = VALUE_WIDTH'(in_value);
      end
      if (cmd.ins_shift) begin
         k_in = k_m1;
      end
      if (cmd.ins_put) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.rem_take) begin
         count_in = count_m1;
         value_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         count_ff <= count_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (cmd.accept) begin
         remove_ff <= req_type;
         status_ff <= status_new;
      end
      if (cmd.load_rsp) begin
         rsp_vld_ff    <= remove_ff && (status_ff == mpq_pkg::STATUS_OK);
         rsp_value_ff  <= (remove_ff && (status_ff == mpq_pkg::STATUS_OK))
                          ? OVW'(value_ff) : '0;
         rsp_status_ff <= status_ff;
         rsp_fill_ff   <= FCW'(count_ff);
      end
   end

   // entries held in ascending order; the largest sits at count - 1
   always_comb begin
      rd_en = cmd.rem_read || cmd.ins_read || cmd.ins_shift;
      if (cmd.rem_read) begin
         rd_addr = count_m1[AW-1:0];
      end else if (cmd.ins_shift) begin
         rd_addr = k_m2[AW-1:0];
      end else begin
         rd_addr = k_m1[AW-1:0];
      end
      wr_en   = cmd.ins_shift || cmd.ins_put;
      wr_data = cmd.ins_shift ? rd_data : value_ff;
   end

   mpq_ram #(
      .DATA_WIDTH (VALUE_WIDTH),
      .DEPTH      (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (k_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.is_remove    = (remove_ff == mpq_pkg::REQ_REMOVE);
      sts.is_ok        = (status_ff == mpq_pkg::STATUS_OK);
      sts.k_zero       = (k_ff == '0);
      sts.k_one        = (k_ff == CW'(1));
      sts.shift_needed = (rd_data > value_ff);
   end

   assign out_value  = rsp_value_ff;
   assign out_valid  = rsp_vld_ff;
   assign status     = rsp_status_ff;
   assign fill_count = rsp_fill_ff;

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_put |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not raise the entry count");

   a_take_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.rem_take |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove did not lower the entry count");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_shift |-> (k_ff != '0) && (k_ff <= count_ff))
      else $error("shift outside the held entries");

endmodule

[rtl/core/max_priority_queue_core.sv]
`timescale 1ns / 1ps

// Channel    Dir  Fields                                        Handshake
// req_chan   in   req_type, in_value                            valid / ready
// rsp_chan   out  out_value, out_valid, status, fill_count      valid / ready
//
// Insert: after the check, each held entry larger than the value moves up one slot,
// one entry a cycle through the single entry RAM, and the value is put in the gap.
// Remove reads and takes the largest entry; a rejected request goes to the result.
// Reset clears the entry count and the walk index; the RAM is never cleared.
// A finished result waits in the output register while the next request is taken.

module max_priority_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   mpq_req_if.sink  req_chan,
   mpq_rsp_if.source rsp_chan
);

   mpq_pkg::mpq_cmd_type cmd;
   mpq_pkg::mpq_sts_type sts;

   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_type   (req_chan.req_type),
      .in_value   (req_chan.in_value),
      .out_value  (rsp_chan.out_value),
      .out_valid  (rsp_chan.out_valid),
      .status     (rsp_chan.status),
      .fill_count (rsp_chan.fill_count)
   );

endmodule
